// ===== design/ymr_pkg.sv =====
// Shared types and constants of the YMODEM packet receiver.
// No dependencies; the modules and the testbench import this package.
package ymr_pkg;

  localparam int unsigned SMALL_PAYLOAD = 128;
  localparam int unsigned LARGE_PAYLOAD = 1024;
  localparam int unsigned LEFT_W        = 11;

  localparam logic [7:0] MAX_RETRIES_RST = 8'd10;

  // configuration register indexes
  localparam logic [7:0] CFG_MAX_RETRIES  = 8'd0;
  localparam logic [7:0] CFG_ENABLE_LARGE = 8'd1;

  // protocol bytes
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;

  // result kinds
  localparam logic [2:0] KIND_DATA = 3'd0;
  localparam logic [2:0] KIND_NAK  = 3'd1;
  localparam logic [2:0] KIND_GOOD = 3'd2;
  localparam logic [2:0] KIND_EOT  = 3'd3;
  localparam logic [2:0] KIND_FAIL = 3'd4;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] out_byte;
    logic       large_packet;
    logic       last;
  } ymr_result_t;

  // what one processed word yields: up to two results
  typedef struct packed {
    logic [1:0]  n_res;
    ymr_result_t r0;
    ymr_result_t r1;
  } ymr_step_t;

endpackage

// ===== design/ymr_in_if.sv =====
// Input channel of the packet receiver: received byte or timeout event.
// Depends on nothing.
interface ymr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

// ===== design/ymr_out_if.sv =====
// Result channel of the packet receiver.
// Depends on nothing.
interface ymr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] out_byte;
  logic       large_packet;
  logic       last;

  modport source (output valid, result_kind, out_byte, large_packet, last, input ready);
  modport sink   (input valid, result_kind, out_byte, large_packet, last, output ready);
endinterface

// ===== design/ymr_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on nothing.
interface ymr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ymr_proto.sv =====
// Packet state machine: header search, block number check, payload CRC-16.
// Depends on ymr_pkg.
module ymr_proto
  import ymr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic [7:0] max_retries,
  input  logic       enable_large,
  output ymr_step_t  step
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_BLKNUM = 3'd1;
  localparam logic [2:0] PH_BLKCMP = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CRCH   = 3'd4;
  localparam logic [2:0] PH_CRCL   = 3'd5;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  logic [2:0]        phase_r, phase_nxt;
  logic [7:0]        retries_r, retries_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crc_hi_r, crc_hi_nxt;
  logic [7:0]        blk_r, blk_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic              large_r, large_nxt;

  logic exhaust;
  logic timeout;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign exhaust = (retries_r <= 8'd1);
  assign timeout = req_type;

  always_comb begin
    phase_nxt   = phase_r;
    retries_nxt = retries_r;
    crc_nxt     = crc_r;
    crc_hi_nxt  = crc_hi_r;
    blk_nxt     = blk_r;
    left_nxt    = left_r;
    large_nxt   = large_r;
    step        = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (!timeout && rx_byte == BYTE_SOH) begin
          large_nxt = 1'b0;
          left_nxt  = LEFT_W'(SMALL_PAYLOAD);
          crc_nxt   = '0;
          phase_nxt = PH_BLKNUM;
        end else if (!timeout && rx_byte == BYTE_STX && enable_large) begin
          large_nxt = 1'b1;
          left_nxt  = LEFT_W'(LARGE_PAYLOAD);
          crc_nxt   = '0;
          phase_nxt = PH_BLKNUM;
        end else if (!timeout && rx_byte == BYTE_EOT) begin
          step.n_res          = 2'd1;
          step.r0.result_kind = KIND_EOT;
          retries_nxt         = max_retries;
        end else begin
          // silent retry: no NAK on a header timeout or junk byte
          if (exhaust) begin
            step.n_res          = 2'd1;
            step.r0.result_kind = KIND_FAIL;
            retries_nxt         = max_retries;
          end else begin
            retries_nxt = retries_r - 8'd1;
          end
        end
      end
      PH_BLKNUM: begin
        if (!timeout) begin
          blk_nxt   = rx_byte;
          phase_nxt = PH_BLKCMP;
        end
      end
      PH_BLKCMP: begin
        if (!timeout && (blk_r ^ rx_byte) == 8'hFF) begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (!timeout) begin
          step.n_res          = 2'd1;
          step.r0.result_kind = KIND_DATA;
          step.r0.out_byte    = rx_byte;
          crc_nxt             = crc_update(crc_r, rx_byte);
          if (left_r <= LEFT_W'(1)) begin
            left_nxt  = '0;
            phase_nxt = PH_CRCH;
          end else begin
            left_nxt = left_r - LEFT_W'(1);
          end
        end
      end
      PH_CRCH: begin
        if (!timeout) begin
          crc_hi_nxt = rx_byte;
          phase_nxt  = PH_CRCL;
        end
      end
      PH_CRCL: begin
        if (!timeout && {crc_hi_r, rx_byte} == crc_r) begin
          step.n_res           = 2'd1;
          step.r0.result_kind  = KIND_GOOD;
          step.r0.out_byte     = blk_r;
          step.r0.large_packet = large_r;
          retries_nxt          = max_retries;
          phase_nxt            = PH_HEADER;
        end
      end
      default: phase_nxt = PH_HEADER;
    endcase

    // failed check in the block number, complement or CRC phases: NAK, then maybe give up
    if ((phase_r == PH_BLKNUM && timeout) ||
        (phase_r == PH_BLKCMP && (timeout || (blk_r ^ rx_byte) != 8'hFF)) ||
        (phase_r == PH_CRCH && timeout) ||
        (phase_r == PH_CRCL && (timeout || {crc_hi_r, rx_byte} != crc_r))) begin
      step.r0.result_kind = KIND_NAK;
      phase_nxt           = PH_HEADER;
      if (exhaust) begin
        step.n_res          = 2'd2;
        step.r1.result_kind = KIND_FAIL;
        retries_nxt         = max_retries;
      end else begin
        step.n_res  = 2'd1;
        retries_nxt = retries_r - 8'd1;
      end
    end

    step.r0.last = (step.n_res == 2'd1);
    step.r1.last = (step.n_res == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      retries_r <= MAX_RETRIES_RST;
      crc_r     <= '0;
      crc_hi_r  <= '0;
      blk_r     <= '0;
      left_r    <= '0;
      large_r   <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      retries_r <= retries_nxt;
      crc_r     <= crc_nxt;
      crc_hi_r  <= crc_hi_nxt;
      blk_r     <= blk_nxt;
      left_r    <= left_nxt;
      large_r   <= large_nxt;
    end
  end

endmodule

// ===== design/ymr_out_buf.sv =====
// Two-entry result queue: takes up to two results a cycle, gives one.
// Depends on ymr_pkg.
module ymr_out_buf
  import ymr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ymr_step_t   step,
  input  logic        pop,
  output logic [1:0]  space,
  output logic        valid,
  output ymr_result_t head
);

  ymr_result_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign valid = (cnt_r != 2'd0);
  assign head  = q0_r;
  // slots free once this cycle's word has left
  assign space = 2'd2 - cnt_r + {1'b0, pop};

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
    if (push && step.n_res != 2'd0) begin
      if (cnt_nxt == 2'd0) begin
        q0_nxt = step.r0;
      end else begin
        q1_nxt = step.r0;
      end
      if (step.n_res == 2'd2) begin
        q1_nxt = step.r1;
      end
      cnt_nxt = cnt_nxt + step.n_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

// ===== design/ymodem_packet_receiver.sv =====
// Top level of the YMODEM packet receiver: input register, config, queue.
// Depends on ymr_pkg, the three channel interfaces, ymr_proto, ymr_out_buf.
//
// Usage:
//   in_if  : one word per received byte (req_type 0) or timeout (req_type 1).
//   out_if : results - payload bytes, NAK requests, packet good with block
//            number, end of transmission and retries exhausted. last marks
//            the final result of one input word.
//   cfg_if : register writes (index 0 max_retries, 1 enable_large), always
//            ready; write only while the block is idle.
// Timing: a word is registered on acceptance and then processed into the
//   result queue, whose head drives out_if. One word enters per cycle as
//   long as the two-entry result queue has room; a word that yields NAK
//   plus failure puts two results in the queue, which out_if gives one
//   at a time.
// Reset: packet state at header search, retry budget 10, large packets off.
// When out_if stalls, the queue fills, the input register holds its word
//   and in_if.ready falls; nothing is dropped.
module ymodem_packet_receiver
  import ymr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ymr_in_if.sink     in_if,
  ymr_out_if.source  out_if,
  ymr_cfg_if.sink    cfg_if
);

  logic       in_valid_r;
  logic       in_req_r;
  logic [7:0] in_byte_r;

  logic [7:0] max_retries_r;
  logic       enable_large_r;

  ymr_step_t   step;
  ymr_result_t head;
  logic [1:0]  space;
  logic        fire;
  logic        pop;
  logic        q_valid;

  assign fire        = in_valid_r && (step.n_res <= space);
  assign in_if.ready = !in_valid_r || fire;
  assign pop         = q_valid && out_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
    if (in_if.valid && in_if.ready) begin
      in_req_r  <= in_if.req_type;
      in_byte_r <= in_if.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r  <= MAX_RETRIES_RST;
      enable_large_r <= 1'b0;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == CFG_MAX_RETRIES) begin
        max_retries_r <= cfg_if.data;
      end
      if (cfg_if.index == CFG_ENABLE_LARGE) begin
        enable_large_r <= cfg_if.data[0];
      end
    end
  end

  ymr_proto u_proto (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .req_type     (in_req_r),
    .rx_byte      (in_byte_r),
    .max_retries  (max_retries_r),
    .enable_large (enable_large_r),
    .step         (step)
  );

  ymr_out_buf u_out_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .step  (step),
    .pop   (pop),
    .space (space),
    .valid (q_valid),
    .head  (head)
  );

  assign out_if.valid        = q_valid;
  assign out_if.result_kind  = head.result_kind;
  assign out_if.out_byte     = head.out_byte;
  assign out_if.large_packet = head.large_packet;
  assign out_if.last         = head.last;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for ymodem_packet_receiver: a directed table, then
// random packet traffic, each word predicted and checked in order.
// Depends on ymr_pkg, the three channel interfaces and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ymr_pkg::*;

  localparam int unsigned LIMIT       = 500000;
  localparam int          LAT         = 8;
  localparam int          HOLD_CYCLES = 300;
  localparam int          N_DIR       = 21;
  localparam logic [7:0]  CFG_UNUSED  = 8'hFF;

  localparam ymr_result_t R_NONE = '0;
  localparam ymr_result_t R_EOT  = '{result_kind: KIND_EOT, out_byte: 8'h00,
                                     large_packet: 1'b0, last: 1'b1};
  localparam ymr_result_t R_NAK  = '{result_kind: KIND_NAK, out_byte: 8'h00,
                                     large_packet: 1'b0, last: 1'b1};
  localparam ymr_result_t R_FAIL = '{result_kind: KIND_FAIL, out_byte: 8'h00,
                                     large_packet: 1'b0, last: 1'b1};
  localparam ymr_step_t S_NONE = '0;
  localparam ymr_step_t S_EOT  = '{n_res: 2'd1, r0: R_EOT, r1: R_NONE};
  localparam ymr_step_t S_NAK  = '{n_res: 2'd1, r0: R_NAK, r1: R_NONE};
  localparam ymr_step_t S_FAIL = '{n_res: 2'd1, r0: R_FAIL, r1: R_NONE};

  typedef enum logic [2:0] {
    P_HEADER, P_BLKNUM, P_BLKCMP, P_DATA, P_CRCH, P_CRCL
  } rx_phase_t;

  typedef enum int {
    FL_NONE, FL_CMP, FL_TMO_BLK, FL_TMO_CMP, FL_TMO_CRCH, FL_TMO_CRCL, FL_CRC
  } flaw_t;

  typedef struct packed {
    logic      tmo;
    logic [7:0] data;
    logic      typed;
    ymr_step_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ymr_in_if  in_if();
  ymr_out_if out_if();
  ymr_cfg_if cfg_if();

  ymodem_packet_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver model state
  logic [7:0]        max_sh;
  logic              large_sh;
  rx_phase_t         rx_ph;
  logic [7:0]        retries;
  logic [15:0]       crc_run;
  logic [7:0]        crc_hi;
  logic [7:0]        blk_no;
  logic [LEFT_W-1:0] left;
  logic              pkt_large;

  ymr_result_t due_results[$];
  dir_row_t    dir_tab [0:N_DIR-1];
  int          n_fail   = 0;
  int          n_words  = 0;
  int          src_idle = 0;
  int          snk_idle = 0;
  bit          hold_req = 1'b0;
  int unsigned cycle_cnt = 0;

  function automatic logic [15:0] crc16_upd(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int k = 0; k < 8; k++)
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  function automatic void add_res(inout ymr_step_t s, input logic [2:0] k,
                                  input logic [7:0] v, input logic lg);
    ymr_result_t r;
    r = '{result_kind: k, out_byte: v, large_packet: lg, last: 1'b0};
    if (s.n_res == 2'd0) s.r0 = r;
    else s.r1 = r;
    s.n_res = s.n_res + 2'd1;
  endfunction

  function automatic void spend_retry(inout ymr_step_t s);
    if (retries <= 8'd1) begin
      add_res(s, KIND_FAIL, 8'h00, 1'b0);
      retries = max_sh;
    end else begin
      retries = retries - 8'd1;
    end
  endfunction

  function automatic void nak_retry(inout ymr_step_t s);
    add_res(s, KIND_NAK, 8'h00, 1'b0);
    spend_retry(s);
    rx_ph = P_HEADER;
  endfunction

  function automatic ymr_step_t ymodem_step(input logic tmo, input logic [7:0] b);
    ymr_step_t s;
    s = '0;
    case (rx_ph)
      P_HEADER: begin
        if (tmo) begin
          spend_retry(s);
        end else if (b == BYTE_SOH || (b == BYTE_STX && large_sh)) begin
          pkt_large = (b == BYTE_STX);
          left      = pkt_large ? LEFT_W'(LARGE_PAYLOAD) : LEFT_W'(SMALL_PAYLOAD);
          crc_run   = '0;
          rx_ph     = P_BLKNUM;
        end else if (b == BYTE_EOT) begin
          add_res(s, KIND_EOT, 8'h00, 1'b0);
          retries = max_sh;
        end else begin
          spend_retry(s);
        end
      end
      P_BLKNUM: begin
        if (tmo) nak_retry(s);
        else begin
          blk_no = b;
          rx_ph  = P_BLKCMP;
        end
      end
      P_BLKCMP: begin
        if (tmo || (blk_no ^ b) != 8'hFF) nak_retry(s);
        else rx_ph = P_DATA;
      end
      P_DATA: begin
        // timeouts mid-payload are dropped without a word of output
        if (!tmo) begin
          add_res(s, KIND_DATA, b, 1'b0);
          crc_run = crc16_upd(crc_run, b);
          if (left <= 1) begin
            left  = '0;
            rx_ph = P_CRCH;
          end else begin
            left = left - 1'b1;
          end
        end
      end
      P_CRCH: begin
        if (tmo) nak_retry(s);
        else begin
          crc_hi = b;
          rx_ph  = P_CRCL;
        end
      end
      P_CRCL: begin
        if (tmo || {crc_hi, b} != crc_run) nak_retry(s);
        else begin
          add_res(s, KIND_GOOD, blk_no, pkt_large);
          retries = max_sh;
          rx_ph   = P_HEADER;
        end
      end
      default: rx_ph = P_HEADER;
    endcase
    if (s.n_res == 2'd1) s.r0.last = 1'b1;
    else if (s.n_res == 2'd2) s.r1.last = 1'b1;
    return s;
  endfunction

  task automatic push_word(input logic tmo, input logic [7:0] data, input logic typed,
                           input ymr_step_t want);
    ymr_step_t s;
    bit        ignored;
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= tmo;
    in_if.rx_byte  <= data;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    ignored = tmo && (rx_ph == P_DATA);
    s = ymodem_step(tmo, data);
    if (typed) s = want;
    if (s.n_res != 2'd0) due_results.push_back(s.r0);
    if (s.n_res == 2'd2) due_results.push_back(s.r1);
    if (!ignored) n_words++;
  endtask

  task automatic put(input logic tmo, input logic [7:0] data);
    push_word(tmo, data, 1'b0, S_NONE);
  endtask

  task automatic send_packet(input bit lg, input flaw_t flaw);
    logic [7:0]  blk;
    logic [7:0]  d;
    logic [15:0] crc;
    int          len;
    blk = 8'($urandom_range(255));
    crc = '0;
    len = lg ? LARGE_PAYLOAD : SMALL_PAYLOAD;
    put(1'b0, lg ? BYTE_STX : BYTE_SOH);
    if (flaw == FL_TMO_BLK) begin
      put(1'b1, 8'($urandom_range(255)));
      return;
    end
    put(1'b0, blk);
    if (flaw == FL_TMO_CMP) begin
      put(1'b1, 8'($urandom_range(255)));
      return;
    end
    if (flaw == FL_CMP) begin
      put(1'b0, ~blk ^ (8'h01 << $urandom_range(7)));
      return;
    end
    put(1'b0, ~blk);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(31) == 0) put(1'b1, 8'($urandom_range(255)));
      // bias towards header bytes so they turn up as payload
      d = ($urandom_range(7) == 0) ? {5'd0, 3'($urandom_range(4))} : 8'($urandom_range(255));
      crc = crc16_upd(crc, d);
      put(1'b0, d);
    end
    if (flaw == FL_CRC) crc = crc ^ (16'h0001 << $urandom_range(15));
    if (flaw == FL_TMO_CRCH) begin
      put(1'b1, 8'($urandom_range(255)));
      return;
    end
    put(1'b0, crc[15:8]);
    if (flaw == FL_TMO_CRCL) begin
      put(1'b1, 8'($urandom_range(255)));
      return;
    end
    put(1'b0, crc[7:0]);
  endtask

  task automatic random_traffic(input int n_items);
    int         start;
    int         pick;
    logic [7:0] d;
    flaw_t      flaw;
    start = n_words;
    while (n_words - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_packet(1'b0, FL_NONE);
      end else if (pick < 40) begin
        send_packet(1'b0, FL_CRC);
      end else if (pick < 62) begin
        flaw = flaw_t'($urandom_range(FL_TMO_CRCL, FL_CMP));
        // large headers only with the flaws that end before the payload
        send_packet(large_sh && flaw <= FL_TMO_CMP && $urandom_range(1) == 0, flaw);
      end else if (pick < 72) begin
        put(1'b0, BYTE_EOT);
      end else if ($urandom_range(1) == 0) begin
        put(1'b1, 8'($urandom_range(255)));
      end else begin
        // stray byte: keep it from opening an accepted packet
        d = 8'($urandom_range(255));
        if (d == BYTE_SOH || (d == BYTE_STX && large_sh)) d = 8'h00;
        put(1'b0, d);
      end
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic reg_write(input logic [7:0] idx, input logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_MAX_RETRIES) max_sh = val;
    else if (idx == CFG_ENABLE_LARGE) large_sh = val[0];
    @(posedge clk);
  endtask

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  // receiver side: random back-pressure, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    ymr_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d, byte %0h",
               out_if.result_kind, out_if.out_byte);
        n_fail++;
      end else begin
        want = due_results.pop_front();
        cmp_field("result_kind", 8'(want.result_kind), 8'(out_if.result_kind));
        cmp_field("out_byte", want.out_byte, out_if.out_byte);
        cmp_field("large_packet", 8'(want.large_packet), 8'(out_if.large_packet));
        cmp_field("last", 8'(want.last), 8'(out_if.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("ymodem_packet_receiver: mismatch");
      $finish;
    end
  end

  initial begin
    in_if.valid    = 1'b0;
    in_if.req_type = 1'b0;
    in_if.rx_byte  = 8'h00;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = 8'h00;
    cfg_if.data    = 8'h00;
    rst_n          = 1'b0;

    max_sh    = MAX_RETRIES_RST;
    large_sh  = 1'b0;
    rx_ph     = P_HEADER;
    retries   = MAX_RETRIES_RST;
    crc_run   = '0;
    crc_hi    = '0;
    blk_no    = '0;
    left      = '0;
    pkt_large = 1'b0;

    // budget starts at 10; rows with typed = 0 go through the model alone
    dir_tab = '{
      '{1'b1, 8'h00, 1'b1, S_NONE},   // header timeout
      '{1'b0, 8'h00, 1'b1, S_NONE},   // junk header bytes
      '{1'b0, 8'hFF, 1'b1, S_NONE},
      '{1'b0, BYTE_STX, 1'b1, S_NONE}, // large packets still off
      '{1'b0, BYTE_EOT, 1'b1, S_EOT},
      '{1'b0, BYTE_SOH, 1'b0, S_NONE},
      '{1'b1, 8'hA5, 1'b1, S_NAK},    // timeout on block number
      '{1'b0, BYTE_SOH, 1'b0, S_NONE},
      '{1'b0, 8'h00, 1'b0, S_NONE},
      '{1'b0, 8'hFE, 1'b1, S_NAK},    // complement off by one bit
      '{1'b0, BYTE_SOH, 1'b0, S_NONE},
      '{1'b0, 8'hFF, 1'b0, S_NONE},
      '{1'b1, 8'h5A, 1'b1, S_NAK},    // timeout on complement
      '{1'b1, 8'h00, 1'b1, S_NONE},
      '{1'b1, 8'hFF, 1'b1, S_NONE},
      '{1'b1, 8'h00, 1'b1, S_NONE},
      '{1'b1, 8'hFF, 1'b1, S_NONE},
      '{1'b1, 8'h00, 1'b1, S_NONE},
      '{1'b1, 8'hFF, 1'b1, S_NONE},
      '{1'b1, 8'h00, 1'b1, S_FAIL},   // budget gone
      '{1'b0, BYTE_EOT, 1'b1, S_EOT}
    };

    src_idle = 12;
    snk_idle = 63;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      push_word(dir_tab[i].tmo, dir_tab[i].data, dir_tab[i].typed, dir_tab[i].res);
    settle();

    reg_write(CFG_MAX_RETRIES, 8'd255);
    reg_write(CFG_ENABLE_LARGE, 8'hFF);
    hold_req = 1'b1;
    send_packet(1'b0, FL_NONE);
    random_traffic(90);
    settle();

    src_idle = 63;
    snk_idle = 12;
    reg_write(CFG_MAX_RETRIES, 8'd1);
    reg_write(CFG_ENABLE_LARGE, 8'hFE);
    reg_write(CFG_UNUSED, 8'h5A);
    random_traffic(70);
    settle();

    src_idle = 0;
    snk_idle = 0;
    reg_write(CFG_MAX_RETRIES, 8'd0);
    reg_write(CFG_ENABLE_LARGE, 8'h01);
    random_traffic(50);
    settle();

    reg_write(CFG_MAX_RETRIES, 8'd3);
    random_traffic(40);
    settle();

    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      n_fail++;
    end
    if (n_fail == 0) $display("ymodem_packet_receiver: match");
    else $display("ymodem_packet_receiver: mismatch");
    $finish;
  end

endmodule
